@@ src/spq_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, codes and constants for the sorted priority queue.
// No dependencies; used by spq_cell and sorted_priority_queue.
package spq_pkg;

	// Default number of entries the queue can hold
	localparam int DEF_CAPACITY = 16;

	// Width of the reported entry count
	localparam int CNT_OUT_W = 5;

	// Request action codes
	localparam logic ACT_ENQ = 1'b0;
	localparam logic ACT_DEQ = 1'b1;

	// Result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// Operation broadcast to every cell
	typedef enum logic [1:0] {
		OP_HOLD,
		OP_ENQ,
		OP_DEQ
	} cell_op_t;

	// One stored entry
	typedef struct packed {
		logic [31:0] payload;
		logic [31:0] prio;
	} entry_t;

	// Broadcast command to the cell row
	typedef struct packed {
		cell_op_t op;
		entry_t   ent;
	} cell_cmd_t;

	// Request item
	typedef struct packed {
		logic        action;
		logic [31:0] payload;
		logic [31:0] priority_req;
	} req_t;

	// Result item
	typedef struct packed {
		logic [31:0]          out_payload;
		logic [31:0]          out_priority;
		logic [1:0]           status;
		logic [CNT_OUT_W-1:0] entry_count;
		logic                 is_empty;
	} rsp_t;

endpackage

@@ src/spq_cell.sv @@
`timescale 1ns / 1ps
// One slot of the sorted cell row: holds an entry, compares it with the
// broadcast entry and shifts toward its neighbors. Depends on spq_pkg.
module spq_cell import spq_pkg::*; #(
	parameter int INDEX = 0,
	parameter int CNT_W = 5
) (
	input  logic             clk,
	input  cell_cmd_t        cmd,
	input  logic [CNT_W-1:0] held_count,
	input  logic             left_keep,
	input  entry_t           left_ent,
	input  entry_t           right_ent,
	output entry_t           ent,
	output logic             keep
);

	entry_t ent_q;

	// Slot stays put on enqueue when it is held and ranks at or above the new entry
	assign keep = (held_count > CNT_W'(INDEX)) && (ent_q.prio >= cmd.ent.prio);
	assign ent  = ent_q;

	// Shift or load
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_ENQ: begin
				if (!keep) begin
					if (left_keep) begin
						ent_q <= cmd.ent;
					end else begin
						ent_q <= left_ent;
					end
				end
			end
			OP_DEQ: begin
				ent_q <= right_ent;
			end
			default: begin
				ent_q <= ent_q;
			end
		endcase
	end

endmodule

@@ src/sorted_priority_queue.sv @@
`timescale 1ns / 1ps
// Sorted priority queue, highest priority first, ties in arrival order.
// Request channel: req_valid / req_stall / req. Each item enqueues
// req.payload with req.priority_req (action 0) or dequeues the head
// (action 1). Every item returns one result on rsp_valid / rsp_stall / rsp:
// the dequeued entry (zero otherwise), a status (ok, dequeue on empty,
// enqueue dropped because full), the entry count and an empty flag.
// Entries live in a row of CAPACITY cells; all cells compare against the
// new entry and shift in the same cycle, so one item is taken per cycle
// while req_stall is low; its result goes to the result or skid register.
// A result register plus one skid entry sit at the output: while the
// receiver stalls, one more item is still accepted, then req_stall rises
// until the receiver takes a result.
// Reset clears the entry count and the output valid flags; the cell
// contents are not reset and are only read for held slots.
// Depends on spq_pkg and spq_cell.
module sorted_priority_queue import spq_pkg::*; #(
	parameter int CAPACITY = DEF_CAPACITY
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_next;
	logic             accept;
	logic             full;
	cell_cmd_t        cmd;
	rsp_t             result;
	entry_t           cell_ent  [CAPACITY];
	logic             cell_keep [CAPACITY];
	logic [CNT_W+CNT_OUT_W-1:0] cnt_ext;

	rsp_t out_q;
	logic out_valid_q;
	rsp_t skid_q;
	logic skid_valid_q;
	logic out_take;

	assign req_stall = skid_valid_q;
	assign accept    = req_valid && !skid_valid_q;
	assign full      = (cnt_q == CNT_W'(CAPACITY));

	// Decode the item into a cell command and its result
	always_comb begin
		cmd.op   = OP_HOLD;
		cmd.ent  = '{payload: req.payload, prio: req.priority_req};
		cnt_next = cnt_q;
		result   = '0;
		if (req.action == ACT_ENQ) begin
			if (full) begin
				result.status = ST_FULL;
			end else begin
				cmd.op   = accept ? OP_ENQ : OP_HOLD;
				cnt_next = cnt_q + 1'b1;
				result.status = ST_OK;
			end
		end else begin
			if (cnt_q == '0) begin
				result.status = ST_EMPTY;
			end else begin
				cmd.op   = accept ? OP_DEQ : OP_HOLD;
				cnt_next = cnt_q - 1'b1;
				result.out_payload  = cell_ent[0].payload;
				result.out_priority = cell_ent[0].prio;
				result.status       = ST_OK;
			end
		end
		cnt_ext = {{CNT_OUT_W{1'b0}}, cnt_next};
		result.entry_count = cnt_ext[CNT_OUT_W-1:0];
		result.is_empty    = (cnt_next == '0);
	end

	// Cell row
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic   lk;
		entry_t le;
		entry_t re;
		if (i == 0) begin : g_head
			assign lk = 1'b1;
			assign le = cmd.ent;
		end else begin : g_mid
			assign lk = cell_keep[i-1];
			assign le = cell_ent[i-1];
		end
		if (i == CAPACITY - 1) begin : g_tail
			assign re = cell_ent[i];
		end else begin : g_body
			assign re = cell_ent[i+1];
		end
		spq_cell #(
			.INDEX (i),
			.CNT_W (CNT_W)
		) u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.held_count (cnt_q),
			.left_keep  (lk),
			.left_ent   (le),
			.right_ent  (re),
			.ent        (cell_ent[i]),
			.keep       (cell_keep[i])
		);
	end

	// Entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			cnt_q <= cnt_next;
		end
	end

	// Result register with one skid entry
	assign out_take = out_valid_q && !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				if (!out_valid_q || out_take) begin
					out_valid_q <= 1'b1;
				end else begin
					skid_valid_q <= 1'b1;
				end
			end else if (out_take) begin
				if (skid_valid_q) begin
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (!out_valid_q || out_take) begin
				out_q <= result;
			end else begin
				skid_q <= result;
			end
		end else if (out_take && skid_valid_q) begin
			out_q <= skid_q;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for sorted_priority_queue: a directed table, then random traffic.
// Depends on spq_pkg and the sorted_priority_queue RTL; results are checked in order.
module tb;
	import spq_pkg::*;

	localparam int CAPACITY      = DEF_CAPACITY;
	localparam int RANDOM_CHUNKS = 16;
	localparam int CHUNK_ITEMS   = 100;
	localparam int MAX_GAP       = 14;
	localparam int LONG_HOLD     = 80;
	localparam int DRAIN_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 20;
	localparam int REPORT_LIMIT  = 10;
	localparam int TIMEOUT_NS    = 5_000_000;

	// One row of the directed table
	typedef struct {
		req_t item;
		bit   typed;
		rsp_t want;
	} stim_row_t;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	// Predicted queue contents, head in slot 0
	logic [31:0] held_pay  [CAPACITY];
	logic [31:0] held_prio [CAPACITY];
	int          held_n = 0;

	rsp_t      awaited_results [$];
	stim_row_t directed_rows [$];

	int gap_choice [3] = '{0, 4, MAX_GAP};
	int pct_choice [5] = '{25, 50, 50, 75, 95};

	int send_max     = MAX_GAP;
	int recv_max     = MAX_GAP;
	int long_hold    = 0;
	int fail_count   = 0;
	int items_sent   = 0;
	int popped       = 0;
	int empty_hits   = 0;
	int full_hits    = 0;
	int peak_held    = 0;
	int stall_cycles = 0;

	sorted_priority_queue #(
		.CAPACITY(CAPACITY)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Cycles in which an offered item is held back by the block
	always @(posedge clk) begin
		if (req_valid && req_stall === 1'b1)
			stall_cycles++;
	end

	// Expected result of one item; updates the predicted queue
	function automatic rsp_t apply_request(input req_t r);
		rsp_t res;
		int   pos;
		res = '0;
		if (r.action == ACT_ENQ) begin
			if (held_n >= CAPACITY) begin
				res.status = ST_FULL;
				full_hits++;
			end else begin
				// new entry goes behind every entry of equal or higher priority
				pos = 0;
				while (pos < held_n && held_prio[pos] >= r.priority_req)
					pos++;
				for (int i = held_n; i > pos; i--) begin
					held_pay[i]  = held_pay[i-1];
					held_prio[i] = held_prio[i-1];
				end
				held_pay[pos]  = r.payload;
				held_prio[pos] = r.priority_req;
				held_n++;
				res.status = ST_OK;
			end
		end else if (held_n == 0) begin
			res.status = ST_EMPTY;
			empty_hits++;
		end else begin
			res.out_payload  = held_pay[0];
			res.out_priority = held_prio[0];
			for (int i = 1; i < held_n; i++) begin
				held_pay[i-1]  = held_pay[i];
				held_prio[i-1] = held_prio[i];
			end
			held_n--;
			popped++;
			res.status = ST_OK;
		end
		res.entry_count = held_n[CNT_OUT_W-1:0];
		res.is_empty    = (held_n == 0);
		if (held_n > peak_held)
			peak_held = held_n;
		return res;
	endfunction

	// Result typed in by hand; empty flag follows the count
	function automatic rsp_t outcome(input logic [31:0] pay, input logic [31:0] prio,
			input logic [1:0] st, input int cnt);
		rsp_t res;
		res.out_payload  = pay;
		res.out_priority = prio;
		res.status       = st;
		res.entry_count  = cnt[CNT_OUT_W-1:0];
		res.is_empty     = (cnt == 0);
		return res;
	endfunction

	function automatic stim_row_t row(input logic act, input logic [31:0] pay,
			input logic [31:0] prio, input bit typed = 1'b0, input rsp_t want = '0);
		stim_row_t s;
		s.item.action       = act;
		s.item.payload      = pay;
		s.item.priority_req = prio;
		s.typed             = typed;
		s.want              = want;
		return s;
	endfunction

	// Random item; priorities lean on a small range so ties are common
	function automatic req_t random_item(input int enq_pct);
		req_t r;
		int   sel;
		r.action  = ($urandom_range(0, 99) < enq_pct) ? ACT_ENQ : ACT_DEQ;
		r.payload = $urandom();
		sel = $urandom_range(0, 9);
		if (sel == 0)
			r.priority_req = '0;
		else if (sel == 1)
			r.priority_req = 32'hFFFF_FFFF - $urandom_range(0, 2);
		else if (sel < 6)
			r.priority_req = $urandom_range(0, 7);
		else
			r.priority_req = $urandom();
		return r;
	endfunction

	task automatic flag(input string what);
		fail_count++;
		if (fail_count <= REPORT_LIMIT)
			$display("%0t ERROR: %s", $time, what);
	endtask

	// Offer one item until taken, record its expected result, then pause for a random gap, which may be zero
	task automatic send_item(input req_t item, input bit typed, input rsp_t want);
		rsp_t guess;
		int   gap;
		req_valid <= 1'b1;
		req       <= item;
		do
			@(posedge clk);
		while (req_stall !== 1'b0);
		guess = apply_request(item);
		awaited_results.push_back(typed ? want : guess);
		items_sent++;
		gap = $urandom_range(0, send_max);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Sender stops until every result is back
	task automatic drain_pause();
		req_valid <= 1'b0;
		do
			@(posedge clk);
		while (awaited_results.size() != 0);
	endtask

	// Result side: random stall per item, occasional long hold-off
	initial begin : result_side
		rsp_t want;
		int   gap;
		wait (arst_n === 1'b1);
		forever begin
			if (long_hold > 0) begin
				gap = long_hold;
				long_hold = 0;
			end else begin
				gap = $urandom_range(0, recv_max);
			end
			if (gap > 0) begin
				rsp_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			do
				@(posedge clk);
			while (rsp_valid !== 1'b1);
			if (awaited_results.size() == 0) begin
				flag($sformatf("result with nothing outstanding: %h", rsp));
			end else begin
				want = awaited_results.pop_front();
				if (rsp.out_payload !== want.out_payload)
					flag($sformatf("out_payload expected %h got %h",
						want.out_payload, rsp.out_payload));
				if (rsp.out_priority !== want.out_priority)
					flag($sformatf("out_priority expected %h got %h",
						want.out_priority, rsp.out_priority));
				if (rsp.status !== want.status)
					flag($sformatf("status expected %0d got %0d", want.status, rsp.status));
				if (rsp.entry_count !== want.entry_count)
					flag($sformatf("entry_count expected %0d got %0d",
						want.entry_count, rsp.entry_count));
				if (rsp.is_empty !== want.is_empty)
					flag($sformatf("is_empty expected %0d got %0d", want.is_empty, rsp.is_empty));
			end
		end
	end

	// Stimulus: directed table, random chunks, then drain and report
	initial begin : stimulus
		logic [31:0] fill_prio [16];
		int          enq_pct;
		fill_prio = '{32'd5, 32'hFFFF_FFFF, 32'd5, 32'd0, 32'd7, 32'd5, 32'h8000_0000, 32'd0,
			32'd7, 32'h7FFF_FFFF, 32'd5, 32'd1, 32'hFFFF_FFFE, 32'd7, 32'd0, 32'd5};

		// empty queue, extremes and a tie at priority zero
		directed_rows.push_back(row(ACT_DEQ, '0, '0, 1'b1, outcome('0, '0, ST_EMPTY, 0)));
		directed_rows.push_back(row(ACT_ENQ, '0, '0, 1'b1, outcome('0, '0, ST_OK, 1)));
		directed_rows.push_back(row(ACT_ENQ, '1, '1, 1'b1, outcome('0, '0, ST_OK, 2)));
		directed_rows.push_back(row(ACT_ENQ, 32'd1, '0, 1'b1, outcome('0, '0, ST_OK, 3)));
		directed_rows.push_back(row(ACT_DEQ, '0, '0, 1'b1, outcome('1, '1, ST_OK, 2)));
		directed_rows.push_back(row(ACT_DEQ, '1, '1, 1'b1, outcome('0, '0, ST_OK, 1)));
		directed_rows.push_back(row(ACT_DEQ, '0, '0, 1'b1, outcome(32'd1, '0, ST_OK, 0)));
		directed_rows.push_back(row(ACT_DEQ, '1, '1, 1'b1, outcome('0, '0, ST_EMPTY, 0)));
		// fill to capacity with mixed and tied priorities, then overflow
		for (int i = 0; i < 16; i++)
			directed_rows.push_back(row(ACT_ENQ, 32'hA5A5_0000 + i, fill_prio[i]));
		directed_rows.push_back(row(ACT_ENQ, 32'h5A5A_5A5A, '1, 1'b1,
			outcome('0, '0, ST_FULL, CAPACITY)));

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[k])
			send_item(directed_rows[k].item, directed_rows[k].typed, directed_rows[k].want);

		for (int c = 0; c < RANDOM_CHUNKS; c++) begin
			if (c % 4 == 3)
				drain_pause();
			recv_max = gap_choice[$urandom_range(0, 2)];
			enq_pct  = pct_choice[$urandom_range(0, 4)];
			if (c == 5 || c == 12) begin
				// receiver holds off while items keep coming, so the block backs up
				send_max  = 0;
				long_hold = LONG_HOLD;
			end else if (c == 0) begin
				send_max = 0;
				recv_max = 0;
			end else begin
				send_max = gap_choice[$urandom_range(0, 2)];
			end
			for (int n = 0; n < CHUNK_ITEMS; n++)
				send_item(random_item(enq_pct), 1'b0, '0);
		end

		// drain, then allow for stray results
		req_valid <= 1'b0;
		for (int w = 0; w < DRAIN_LIMIT && awaited_results.size() != 0; w++)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (awaited_results.size() != 0)
			flag($sformatf("%0d results never arrived", awaited_results.size()));

		$display("tb: %0d items (%0d from the table), %0d entries served, peak depth %0d",
			items_sent, directed_rows.size(), popped, peak_held);
		$display("tb: %0d dequeues on empty, %0d enqueues refused while full, %0d backpressure cycles",
			empty_hits, full_hits, stall_cycles);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// Watchdog
	initial begin : watchdog
		#(TIMEOUT_NS);
		$display("tb: timeout after %0d items", items_sent);
		$display("tb: failure");
		$finish;
	end

endmodule

@@ sorted_priority_queue.f @@
src/spq_pkg.sv
src/spq_cell.sv
src/sorted_priority_queue.sv
tb/tb.sv
